[hdl/i2a_pkg.sv]
// Shared types, constants and the digit-to-character tables for the integer formatter.
package i2a_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Field widths and character counts all fit the 7-bit field_width encoding.
    localparam int CNT_W   = 7;
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_SCAN
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LPAD,
        BK_SIGN,
        BK_DIGIT,
        BK_RPAD
    } t_back_state;

    typedef struct packed {
        logic             neg;
        logic             ladj;
        logic             zpad;
        logic             upper;
        logic [CNT_W-1:0] width;
        logic [CNT_W-1:0] nd;
    } t_meta;

    localparam logic [7:0] UPPER_TAB [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [7:0] LOWER_TAB [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        digit_char = upper ? UPPER_TAB[d] : LOWER_TAB[d];
    endfunction

endpackage

[hdl/i2a_front.sv]
// Front end: accepts an item, converts the magnitude to a digit vector and finds its length.
module i2a_front #(
    parameter int MAX_WIDTH  = i2a_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_op,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  logic [i2a_pkg::CNT_W-1:0]   i_field_width,
    input  logic                        i_left_adjust,
    input  logic                        i_zero_pad,
    input  logic                        i_upper_digits,
    output logic                        o_busy,
    input  logic                        i_full,
    output logic                        o_push,
    output i2a_pkg::t_meta              o_meta,
    output logic [VALUE_BITS*4-1:0]     o_digits
);
    localparam int DIG_W      = VALUE_BITS * 4;
    // Decimal digits of 2^VALUE_BITS-1, using 1233/4096 as log10(2).
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CW         = i2a_pkg::CNT_W;

    i2a_pkg::t_front_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_shift;
    logic [DIG_W-1:0]      r_dig;
    logic [IDX_W-1:0]      r_bitcnt;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_neg;
    logic                  r_ladj;
    logic                  r_zpad;
    logic                  r_upper;
    logic [CW-1:0]         r_width;

    logic                  accept;
    i2a_pkg::t_op          op;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [CW-1:0]         wsat;
    logic [DIG_W-1:0]      bin_dig;
    logic [DIG_W-1:0]      dd_adj;
    logic [DIG_W-1:0]      dd_next;
    logic [3:0]            cur_digit;
    logic                  found;

    assign accept = i_start && (r_state == i2a_pkg::FR_IDLE);
    assign op     = i2a_pkg::t_op'(i_op);
    assign neg    = (op == i2a_pkg::OP_SDEC) && i_value[VALUE_BITS-1];
    assign mag    = neg ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;
    assign wsat   = (i_field_width > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : i_field_width;

    always_comb begin
        bin_dig = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            bin_dig[4*i +: 4] = {3'b000, mag[i]};
        end
    end

    // One double-dabble step: add three to every BCD digit of five or more, then shift.
    always_comb begin
        dd_adj = '0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            dd_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? (r_dig[4*i +: 4] + 4'd3)
                                                         : r_dig[4*i +: 4];
        end
        dd_next = '0;
        dd_next[DEC_DIGITS*4-1:0] = {dd_adj[DEC_DIGITS*4-2:0], r_shift[VALUE_BITS-1]};
    end

    assign cur_digit = r_dig[4*r_idx +: 4];
    assign found     = (cur_digit != 4'd0) || (r_idx == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2a_pkg::FR_IDLE: begin
                if (accept) begin
                    n_state = ((op == i2a_pkg::OP_SDEC) || (op == i2a_pkg::OP_UDEC))
                              ? i2a_pkg::FR_CONV : i2a_pkg::FR_SCAN;
                end
            end
            i2a_pkg::FR_CONV: begin
                if (r_bitcnt == '0) begin
                    n_state = i2a_pkg::FR_SCAN;
                end
            end
            i2a_pkg::FR_SCAN: begin
                if (found && !i_full) begin
                    n_state = i2a_pkg::FR_IDLE;
                end
            end
            default: n_state = i2a_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state != i2a_pkg::FR_IDLE);
        o_push        = (r_state == i2a_pkg::FR_SCAN) && found && !i_full;
        o_digits      = r_dig;
        o_meta.neg    = r_neg;
        o_meta.ladj   = r_ladj;
        o_meta.zpad   = r_zpad;
        o_meta.upper  = r_upper;
        o_meta.width  = r_width;
        o_meta.nd     = CW'(r_idx) + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            i2a_pkg::FR_IDLE: begin
                if (accept) begin
                    r_neg    <= neg;
                    r_ladj   <= i_left_adjust;
                    r_zpad   <= i_zero_pad;
                    r_upper  <= i_upper_digits;
                    r_width  <= wsat;
                    r_shift  <= mag;
                    r_bitcnt <= IDX_W'(VALUE_BITS - 1);
                    unique case (op)
                        i2a_pkg::OP_SDEC, i2a_pkg::OP_UDEC: begin
                            r_dig <= '0;
                        end
                        i2a_pkg::OP_HEX: begin
                            r_dig <= DIG_W'(mag);
                            r_idx <= IDX_W'(HEX_DIGITS - 1);
                        end
                        i2a_pkg::OP_BIN: begin
                            r_dig <= bin_dig;
                            r_idx <= IDX_W'(VALUE_BITS - 1);
                        end
                        default: r_dig <= '0;
                    endcase
                end
            end
            i2a_pkg::FR_CONV: begin
                r_dig    <= dd_next;
                r_shift  <= {r_shift[VALUE_BITS-2:0], 1'b0};
                r_bitcnt <= r_bitcnt - IDX_W'(1);
                if (r_bitcnt == '0) begin
                    r_idx <= IDX_W'(DEC_DIGITS - 1);
                end
            end
            i2a_pkg::FR_SCAN: begin
                if (!found) begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

[hdl/i2a_queue.sv]
// Short queue of converted items between the front end and the character sequencer.
module i2a_queue #(
    parameter int DIG_W = i2a_pkg::VALUE_BITS_DEF * 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2a_pkg::t_meta       i_meta,
    input  logic [DIG_W-1:0]     i_digits,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output i2a_pkg::t_meta       o_meta,
    output logic [DIG_W-1:0]     o_digits
);
    localparam int DEPTH = i2a_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2a_pkg::t_meta   r_meta [DEPTH];
    logic [DIG_W-1:0] r_dig  [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full   = (r_cnt == CNT_W'(DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_meta   = r_meta[r_rp];
    assign o_digits = r_dig[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_meta[r_wp] <= i_meta;
            r_dig[r_wp]  <= i_digits;
        end
    end

endmodule

[hdl/i2a_back.sv]
// Back end: emits padding, sign and digits of one field, one character per cycle.
module i2a_back #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  i2a_pkg::t_meta          i_meta,
    input  logic [VALUE_BITS*4-1:0] i_digits,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic [7:0]              o_char_out,
    output logic                    o_last
);
    localparam int DIG_W = VALUE_BITS * 4;
    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CW    = i2a_pkg::CNT_W;

    i2a_pkg::t_back_state r_state, n_state;

    i2a_pkg::t_meta   r_meta;
    logic [DIG_W-1:0] r_dig;
    logic [IDX_W-1:0] r_didx;
    logic [CW-1:0]    r_pad;
    logic [CW-1:0]    r_left;

    logic             load;
    logic [CW-1:0]    ndt;
    logic [CW-1:0]    pad;
    logic [3:0]       cur_digit;

    assign load      = (r_state == i2a_pkg::BK_IDLE) && !i_empty;
    assign ndt       = i_meta.nd + CW'(i_meta.neg);
    assign pad       = (i_meta.width > ndt) ? (i_meta.width - ndt) : '0;
    assign cur_digit = r_dig[4*r_didx +: 4];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2a_pkg::BK_IDLE: begin
                if (load) begin
                    if (!i_meta.ladj && (pad != '0)) begin
                        n_state = i2a_pkg::BK_LPAD;
                    end else if (i_meta.neg) begin
                        n_state = i2a_pkg::BK_SIGN;
                    end else begin
                        n_state = i2a_pkg::BK_DIGIT;
                    end
                end
            end
            i2a_pkg::BK_LPAD: begin
                if (r_pad == CW'(1)) begin
                    n_state = r_meta.neg ? i2a_pkg::BK_SIGN : i2a_pkg::BK_DIGIT;
                end
            end
            i2a_pkg::BK_SIGN: begin
                n_state = i2a_pkg::BK_DIGIT;
            end
            i2a_pkg::BK_DIGIT: begin
                if (r_didx == '0) begin
                    n_state = (r_meta.ladj && (r_pad != '0)) ? i2a_pkg::BK_RPAD
                                                             : i2a_pkg::BK_IDLE;
                end
            end
            i2a_pkg::BK_RPAD: begin
                if (r_pad == CW'(1)) begin
                    n_state = i2a_pkg::BK_IDLE;
                end
            end
            default: n_state = i2a_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = load;
        o_strobe = (r_state != i2a_pkg::BK_IDLE);
        o_last   = o_strobe && (r_left == CW'(1));
        unique case (r_state)
            i2a_pkg::BK_LPAD, i2a_pkg::BK_RPAD: begin
                o_char_out = r_meta.zpad ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
            end
            i2a_pkg::BK_SIGN:  o_char_out = i2a_pkg::CH_MINUS;
            i2a_pkg::BK_DIGIT: o_char_out = i2a_pkg::digit_char(cur_digit, r_meta.upper);
            default:           o_char_out = i2a_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_meta <= i_meta;
            r_dig  <= i_digits;
            r_didx <= IDX_W'(i_meta.nd - CW'(1));
            r_pad  <= pad;
            r_left <= ndt + pad;
        end
        if (o_strobe) begin
            r_left <= r_left - CW'(1);
        end
        case (r_state)
            i2a_pkg::BK_LPAD, i2a_pkg::BK_RPAD: r_pad  <= r_pad - CW'(1);
            i2a_pkg::BK_DIGIT:                  r_didx <= r_didx - IDX_W'(1);
            default: ;
        endcase
    end

endmodule

[hdl/integer_to_ascii_padded.sv]
// Top level of the padded integer-to-ASCII formatter.
//
//  channel  | ports                                              | transfer
//  ---------+----------------------------------------------------+------------------------
//  command  | start, busy, i_op, i_value, i_field_width,         | start high, busy low
//           | i_left_adjust, i_zero_pad, i_upper_digits          |
//  result   | o_strobe, o_char_out, o_last                       | every cycle o_strobe high
//
// For decimal the front end runs double dabble over every value bit and then scans down from
// the top digit for the first nonzero one; for hex and binary it only scans.
// The back end loads one item and then emits max(digits incl. sign, width) characters.
// A two-entry queue lets the front convert the next item while the back emits characters.
// Reset is synchronous and active low; it empties the queue and idles both ends.
// Results cannot be stalled; busy stays high while the front holds an item.
module integer_to_ascii_padded #(
    parameter int MAX_WIDTH  = i2a_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_field_width,
    input  logic        i_left_adjust,
    input  logic        i_zero_pad,
    input  logic        i_upper_digits,
    output logic        o_strobe,
    output logic [7:0]  o_char_out,
    output logic        o_last
);
    localparam int DIG_W = VALUE_BITS * 4;

    logic             q_full;
    logic             q_push;
    logic             q_empty;
    logic             q_pop;
    i2a_pkg::t_meta   f_meta;
    i2a_pkg::t_meta   q_meta;
    logic [DIG_W-1:0] f_digits;
    logic [DIG_W-1:0] q_digits;

    i2a_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_value        (i_value[VALUE_BITS-1:0]),
        .i_field_width  (i_field_width),
        .i_left_adjust  (i_left_adjust),
        .i_zero_pad     (i_zero_pad),
        .i_upper_digits (i_upper_digits),
        .o_busy         (busy),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_meta         (f_meta),
        .o_digits       (f_digits)
    );

    i2a_queue #(
        .DIG_W (DIG_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_meta   (f_meta),
        .i_digits (f_digits),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_meta   (q_meta),
        .o_digits (q_digits)
    );

    i2a_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_meta     (q_meta),
        .i_digits   (q_digits),
        .o_pop      (q_pop),
        .o_strobe   (o_strobe),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

endmodule

[hdl/i2a_checker.sv]
// Port-level checks for the integer formatter, bound to its top level.
module i2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_char_out,
    input logic       o_last
);

    // A last marker only ever comes with a character.
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last marker without a character strobe");

    // An accepted command keeps the front end busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a command transfer");

    // Reset leaves both ends idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("block not idle after reset");

    // Characters are printable ASCII: never a control code or above the 7-bit range.
    a_char_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_char_out >= 8'h20) && (o_char_out <= 8'h7E)))
        else $error("non-printable character transferred");

endmodule

bind integer_to_ascii_padded i2a_checker u_i2a_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_char_out (o_char_out),
    .o_last     (o_last)
);
